### rtl/core/hms_up_down_stopwatch_unit_defines.svh
// Assertion helpers for the stopwatch block.
// Both expect clk and arst_n in scope.
`ifndef HMS_UP_DOWN_STOPWATCH_UNIT_DEFINES_SVH
`define HMS_UP_DOWN_STOPWATCH_UNIT_DEFINES_SVH

// Clocked check of one property, off while reset is asserted.
`define HMS_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define HMS_ASSERT_IMPL(label, ante, cons, msg) \
	`HMS_ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### rtl/core/hms_pkg.sv
`timescale 1ns / 1ps

package hms_pkg;

	localparam int unsigned NumButtons = 7;

	// button positions in the button vector
	localparam int unsigned BTN_MODE     = 0;
	localparam int unsigned BTN_HOUR_UP  = 1;
	localparam int unsigned BTN_HOUR_DN  = 2;
	localparam int unsigned BTN_MIN_UP   = 3;
	localparam int unsigned BTN_MIN_DN   = 4;
	localparam int unsigned BTN_SEC_UP   = 5;
	localparam int unsigned BTN_SEC_DN   = 6;

	localparam logic [5:0] SEC_MAX  = 6'd59;
	localparam logic [6:0] HOUR_MAX = 7'd99;

	typedef struct packed {
		logic                  tick;
		logic                  reset_event;
		logic                  pause_event;
		logic                  resume_event;
		logic [NumButtons-1:0] buttons;
	} sample_t;

	typedef struct packed {
		logic [6:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       down;
		logic       paused;
		logic       buzzer;
	} status_t;

	// tens digit of a value 0..99: x*205 >> 11 is exact over that range
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] p;
		p = {8'd0, v} * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] ones_of(input logic [6:0] v);
		logic [6:0] t10;
		t10 = {3'd0, tens_of(v)} * 7'd10;
		return 4'(v - t10);
	endfunction

endpackage

### rtl/core/hms_up_down_stopwatch_unit.sv
`timescale 1ns / 1ps
// Up/down hours-minutes-seconds stopwatch with countdown buzzer.
// Input channel (in_valid / in_stall): one word per sample, carrying the
// one-second tick, reset/pause/resume pulses and seven button levels.
// Output channel (out_valid / out_stall): one word per sample with the six
// decimal time digits, the mode, the pause flag and the buzzer drive, all as
// they stand after that sample.
// Path: an accepted input word is held in the input register, then the state
// update and digit split write its result into the output register.
// Throughput: one word per cycle while the output does not stall, so a new
// sample may follow each clock.
// A stall on the output holds the output word and the sample in the input
// register; the input channel stalls only once that register is also full.
// Reset clears the time to 00:00:00, count-up mode, running, buzzer off and
// all buttons released; both channels come out of reset empty.
`include "hms_up_down_stopwatch_unit_defines.svh"

module hms_up_down_stopwatch_unit import hms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	input  logic       reset_event,
	input  logic       pause_event,
	input  logic       resume_event,
	input  logic       mode_button,
	input  logic       hour_up_button,
	input  logic       hour_down_button,
	input  logic       minute_up_button,
	input  logic       minute_down_button,
	input  logic       second_up_button,
	input  logic       second_down_button,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] hours_tens,
	output logic [3:0] hours_ones,
	output logic [2:0] minutes_tens,
	output logic [3:0] minutes_ones,
	output logic [2:0] seconds_tens,
	output logic [3:0] seconds_ones,
	output logic       counting_down,
	output logic       is_paused,
	output logic       buzzer_on
);

	sample_t sample_in;
	sample_t sample_s1;
	status_t next_status;
	logic    valid_s1;
	logic    take;
	logic    load;

	always_comb begin
		sample_in.tick         = tick;
		sample_in.reset_event  = reset_event;
		sample_in.pause_event  = pause_event;
		sample_in.resume_event = resume_event;
		sample_in.buttons      = '0;
		sample_in.buttons[BTN_MODE]    = mode_button;
		sample_in.buttons[BTN_HOUR_UP] = hour_up_button;
		sample_in.buttons[BTN_HOUR_DN] = hour_down_button;
		sample_in.buttons[BTN_MIN_UP]  = minute_up_button;
		sample_in.buttons[BTN_MIN_DN]  = minute_down_button;
		sample_in.buttons[BTN_SEC_UP]  = second_up_button;
		sample_in.buttons[BTN_SEC_DN]  = second_down_button;
	end

	// word in the input register moves on when the output register frees up
	assign take     = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	hms_input_stage u_input (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.take      (take),
		.sample_in (sample_in),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1)
	);

	hms_time_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.sample_s1   (sample_s1),
		.next_status (next_status)
	);

	hms_output_stage u_output (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.out_stall     (out_stall),
		.next_status   (next_status),
		.out_valid     (out_valid),
		.hours_tens    (hours_tens),
		.hours_ones    (hours_ones),
		.minutes_tens  (minutes_tens),
		.minutes_ones  (minutes_ones),
		.seconds_tens  (seconds_tens),
		.seconds_ones  (seconds_ones),
		.counting_down (counting_down),
		.is_paused     (is_paused),
		.buzzer_on     (buzzer_on)
	);

	`HMS_ASSERT_IMPL(a_full_stalls_input, valid_s1 && out_valid && out_stall, in_stall, "input accepted while both stages full")
	`HMS_ASSERT_IMPL(a_buzzer_only_down, out_valid && buzzer_on, counting_down, "buzzer sounding in count-up mode")
	`HMS_ASSERT_IMPL(a_ms_digits, out_valid, minutes_tens <= 3'd5 && seconds_tens <= 3'd5 && minutes_ones <= 4'd9 && seconds_ones <= 4'd9, "minute or second digit out of range")
	`HMS_ASSERT_IMPL(a_hour_digits, out_valid, hours_tens <= 4'd9 && hours_ones <= 4'd9, "hour digit out of range")

endmodule

### rtl/core/hms_input_stage.sv
`timescale 1ns / 1ps

module hms_input_stage import hms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    take,
	input  sample_t sample_in,
	output logic    valid_s1,
	output sample_t sample_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= sample_in;
		end
	end

endmodule

### rtl/core/hms_time_core.sv
`timescale 1ns / 1ps

module hms_time_core import hms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  sample_t sample_s1,
	output status_t next_status
);

	logic [6:0]            hours_q;
	logic [5:0]            minutes_q;
	logic [5:0]            seconds_q;
	logic                  down_q;
	logic                  paused_q;
	logic                  armed_q;
	logic                  drive_q;
	logic [NumButtons-1:0] prev_q;
	logic                  armed_nx;

	always_comb begin
		logic [NumButtons-1:0] press;
		logic [6:0] h;
		logic [5:0] m;
		logic [5:0] s;
		logic dn;
		logic pz;
		logic arm;
		logic drv;

		press = sample_s1.buttons & ~prev_q;
		h   = hours_q;
		m   = minutes_q;
		s   = seconds_q;
		dn  = down_q;
		pz  = paused_q;
		arm = armed_q;
		drv = drive_q;

		if (sample_s1.reset_event) begin
			h = '0;
			m = '0;
			s = '0;
		end
		if (sample_s1.pause_event) begin
			pz = 1'b1;
		end
		if (sample_s1.resume_event) begin
			pz = 1'b0;
		end

		if (sample_s1.tick && !pz) begin
			if (!dn) begin
				if (s == SEC_MAX) begin
					s = '0;
					if (m == SEC_MAX) begin
						m = '0;
						h = (h == HOUR_MAX) ? 7'd0 : h + 7'd1;
					end else begin
						m = m + 6'd1;
					end
				end else begin
					s = s + 6'd1;
				end
			end else begin
				priority if (s != '0) begin
					s = s - 6'd1;
				end else if (m != '0) begin
					m = m - 6'd1;
					s = SEC_MAX;
				end else if (h != '0) begin
					// hour borrow lands on 59:59
					h = h - 7'd1;
					m = SEC_MAX;
					s = SEC_MAX;
				end else begin
					// countdown at zero: time holds
					if (arm) begin
						drv = 1'b1;
					end
				end
			end
		end

		if (press[BTN_MODE]) begin
			if (!dn) begin
				dn = 1'b1;
				if (pz) begin
					arm = 1'b1;
				end
			end else begin
				dn  = 1'b0;
				drv = 1'b0;
				arm = 1'b0;
			end
		end

		if (press[BTN_HOUR_UP] && h < HOUR_MAX) h = h + 7'd1;
		if (press[BTN_HOUR_DN] && h != '0)      h = h - 7'd1;
		if (press[BTN_MIN_UP]  && m < SEC_MAX)  m = m + 6'd1;
		if (press[BTN_MIN_DN]  && m != '0)      m = m - 6'd1;
		if (press[BTN_SEC_UP]  && s < SEC_MAX)  s = s + 6'd1;
		if (press[BTN_SEC_DN]  && s != '0)      s = s - 6'd1;

		next_status.hours   = h;
		next_status.minutes = m;
		next_status.seconds = s;
		next_status.down    = dn;
		next_status.paused  = pz;
		next_status.buzzer  = drv;
		armed_nx            = arm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			down_q    <= 1'b0;
			paused_q  <= 1'b0;
			armed_q   <= 1'b0;
			drive_q   <= 1'b0;
			prev_q    <= '0;
		end else if (take) begin
			hours_q   <= next_status.hours;
			minutes_q <= next_status.minutes;
			seconds_q <= next_status.seconds;
			down_q    <= next_status.down;
			paused_q  <= next_status.paused;
			armed_q   <= armed_nx;
			drive_q   <= next_status.buzzer;
			prev_q    <= sample_s1.buttons;
		end
	end

endmodule

### rtl/core/hms_output_stage.sv
`timescale 1ns / 1ps

module hms_output_stage import hms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       out_stall,
	input  status_t    next_status,
	output logic       out_valid,
	output logic [3:0] hours_tens,
	output logic [3:0] hours_ones,
	output logic [2:0] minutes_tens,
	output logic [3:0] minutes_ones,
	output logic [2:0] seconds_tens,
	output logic [3:0] seconds_ones,
	output logic       counting_down,
	output logic       is_paused,
	output logic       buzzer_on
);

	logic       valid_q;
	logic [3:0] h_tens_q;
	logic [3:0] h_ones_q;
	logic [2:0] m_tens_q;
	logic [3:0] m_ones_q;
	logic [2:0] s_tens_q;
	logic [3:0] s_ones_q;
	logic       down_q;
	logic       paused_q;
	logic       buzzer_q;
	logic [3:0] m_tens_w;
	logic [3:0] s_tens_w;

	assign m_tens_w = tens_of({1'b0, next_status.minutes});
	assign s_tens_w = tens_of({1'b0, next_status.seconds});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			h_tens_q <= tens_of(next_status.hours);
			h_ones_q <= ones_of(next_status.hours);
			m_tens_q <= m_tens_w[2:0];
			m_ones_q <= ones_of({1'b0, next_status.minutes});
			s_tens_q <= s_tens_w[2:0];
			s_ones_q <= ones_of({1'b0, next_status.seconds});
			down_q   <= next_status.down;
			paused_q <= next_status.paused;
			buzzer_q <= next_status.buzzer;
		end
	end

	assign out_valid     = valid_q;
	assign hours_tens    = h_tens_q;
	assign hours_ones    = h_ones_q;
	assign minutes_tens  = m_tens_q;
	assign minutes_ones  = m_ones_q;
	assign seconds_tens  = s_tens_q;
	assign seconds_ones  = s_ones_q;
	assign counting_down = down_q;
	assign is_paused     = paused_q;
	assign buzzer_on     = buzzer_q;

endmodule
